// File: hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg - shared types and constants of the fixed block pool allocator
// Field widths, register indexes, result codes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W      = 32;   // address width of the pool memory
    localparam int REQ_W       = 16;   // request size field
    localparam int CFG_W       = 32;   // widest configuration register
    localparam int CFG_IDX_W   = 3;
    localparam int BLK_W       = 7;    // blocks_in_use register
    localparam int STRIDE_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 48;   // request_bytes + release_address
    localparam int M_TDATA_W   = 40;   // block_address + status + fatal, padded

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_REQ  = 3'd0,
        CFG_STRIDE   = 3'd1,
        CFG_BASE     = 3'd2,
        CFG_BLOCKS   = 3'd3,
        CFG_FATAL_EN = 3'd4
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_FREE     = 3'd2,
        ST_NULL_REL    = 3'd3,
        ST_UNKNOWN_REL = 3'd4
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    sweep_clr;     // restart the pool clearing pass
        logic    sweep_step;    // clear one entry of both stores
        logic    pool_load;     // load head, tail and free count
        logic    load_item;     // capture the accepted word
        logic    alloc_commit;  // take the head block
        logic    scan_start;    // begin the release search
        logic    scan_step;     // advance the release search
        logic    rel_commit;    // return the matched block
        logic    res_load;      // load the result register
        t_status res_code;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op;           // 0 allocate, 1 release
        logic too_large;
        logic empty;
        logic rel_null;
        logic sweep_last;
        logic hit;
        logic miss;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hdl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram - generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl - allocator sequencer
// Steps the pool clearing pass, the allocate and release sequences and the
// stream handshakes; drives the datapath by command.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_reinit,
    input  wire logic              i_s_tvalid,
    output      logic              o_s_tready,
    output      logic              o_m_tvalid,
    input  wire logic              i_m_tready,
    output      fbpa_pkg::t_dp_cmd o_cmd,
    input  wire fbpa_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   w_out_free;

    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && !i_reinit;
    assign o_m_tvalid = r_m_tvalid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.res_code  = fbpa_pkg::ST_OK;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.pool_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_out_free) begin
                    if (!i_sts.op) begin
                        priority if (i_sts.too_large) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = fbpa_pkg::ST_TOO_LARGE;
                            n_state        = S_IDLE;
                        end else if (i_sts.empty) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = fbpa_pkg::ST_NO_FREE;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end else if (i_sts.rel_null) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = fbpa_pkg::ST_NULL_REL;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_commit = 1'b1;
                o_cmd.res_load     = 1'b1;
                n_state            = S_IDLE;
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.rel_commit = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_sts.miss) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = fbpa_pkg::ST_UNKNOWN_REL;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        // re-initialisation overrides whatever was under way
        if (i_reinit) begin
            o_cmd           = '0;
            o_cmd.res_code  = fbpa_pkg::ST_OK;
            o_cmd.sweep_clr = 1'b1;
            n_state         = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp - allocator datapath
// Free queue and allocated marks in RAM, queue pointers, free count,
// block address arithmetic, release search pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_dp #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fbpa_pkg::t_dp_cmd                   i_cmd,
    output      fbpa_pkg::t_dp_sts                   o_sts,
    input  wire logic                                i_op,
    input  wire logic [fbpa_pkg::REQ_W-1:0]          i_req,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]         i_rel,
    input  wire logic [fbpa_pkg::REQ_W-1:0]          i_max_req,
    input  wire logic [fbpa_pkg::STRIDE_W-1:0]       i_stride,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]         i_base,
    input  wire logic [fbpa_pkg::BLK_W-1:0]          i_blocks,
    input  wire logic                                i_fatal_en,
    output      logic [fbpa_pkg::ADDR_W-1:0]         o_addr,
    output      logic [fbpa_pkg::STATUS_W-1:0]       o_status,
    output      logic                                o_fatal
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + fbpa_pkg::STRIDE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    // captured item
    logic                          r_op;
    logic [fbpa_pkg::REQ_W-1:0]    r_req;
    logic [fbpa_pkg::ADDR_W-1:0]   r_rel;

    // pool control
    logic [IDX_W-1:0]              r_sweep_idx;
    logic [IDX_W-1:0]              r_head;
    logic [IDX_W-1:0]              r_tail;
    logic [CNT_W-1:0]              r_count;

    // release search: issue stage and compare stage
    logic [IDX_W-1:0]              r_scan_idx;
    logic [fbpa_pkg::ADDR_W-1:0]   r_scan_addr;
    logic                          r_scan_live;
    logic                          r_cmp_vld;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic [fbpa_pkg::ADDR_W-1:0]   r_cmp_addr;

    logic [CNT_W-1:0]              w_n_blocks;
    logic [IDX_W-1:0]              w_init_tail;
    logic [IDX_W-1:0]              w_head_inc;
    logic [IDX_W-1:0]              w_tail_inc;
    logic [IDX_W-1:0]              w_q_rdata;
    logic [0:0]                    w_m_rdata;
    logic [PROD_W-1:0]             w_prod;
    logic [fbpa_pkg::ADDR_W-1:0]   w_alloc_addr;
    logic                          w_q_we;
    logic [IDX_W-1:0]              w_q_waddr;
    logic [IDX_W-1:0]              w_q_wdata;
    logic                          w_m_we;
    logic [IDX_W-1:0]              w_m_waddr;
    logic                          w_hit;

    // managed block count, saturated to the pool depth
    always_comb begin
        if (32'(i_blocks) > 32'(MAX_BLOCKS)) begin
            w_n_blocks = CNT_W'(MAX_BLOCKS);
        end else begin
            w_n_blocks = CNT_W'(i_blocks);
        end
    end

    assign w_init_tail = (w_n_blocks == CNT_W'(MAX_BLOCKS)) ? '0 : IDX_W'(w_n_blocks);
    assign w_head_inc  = (r_head == LAST_IDX) ? '0 : IDX_W'(r_head + 1'b1);
    assign w_tail_inc  = (r_tail == LAST_IDX) ? '0 : IDX_W'(r_tail + 1'b1);

    // block address of the queue head
    assign w_prod       = PROD_W'(w_q_rdata) * PROD_W'(i_stride);
    assign w_alloc_addr = i_base + fbpa_pkg::ADDR_W'(w_prod);

    assign w_hit = r_cmp_vld && w_m_rdata[0] && (r_cmp_addr == r_rel);

    // free queue store
    assign w_q_we    = i_cmd.sweep_step || i_cmd.rel_commit;
    assign w_q_waddr = i_cmd.sweep_step ? r_sweep_idx : r_tail;
    assign w_q_wdata = i_cmd.sweep_step ? r_sweep_idx : r_cmp_idx;

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    // allocated marks store
    assign w_m_we = i_cmd.sweep_step || i_cmd.alloc_commit || i_cmd.rel_commit;
    always_comb begin
        priority if (i_cmd.sweep_step) begin
            w_m_waddr = r_sweep_idx;
        end else if (i_cmd.alloc_commit) begin
            w_m_waddr = w_q_rdata;
        end else begin
            w_m_waddr = r_cmp_idx;
        end
    end

    fbpa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_m_we),
        .i_waddr (w_m_waddr),
        .i_wdata (i_cmd.alloc_commit),
        .i_raddr (r_scan_idx),
        .o_rdata (w_m_rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.too_large  = (r_req > i_max_req);
        o_sts.empty      = (r_count == '0);
        o_sts.rel_null   = (r_rel == '0);
        o_sts.sweep_last = (r_sweep_idx == LAST_IDX);
        o_sts.hit        = w_hit;
        o_sts.miss       = !r_scan_live && !r_cmp_vld;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_scan_live <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            if (i_cmd.sweep_clr) begin
                r_sweep_idx <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep_idx <= (r_sweep_idx == LAST_IDX) ? '0 : IDX_W'(r_sweep_idx + 1'b1);
            end

            if (i_cmd.pool_load) begin
                r_head  <= '0;
                r_tail  <= w_init_tail;
                r_count <= w_n_blocks;
            end else if (i_cmd.alloc_commit) begin
                r_head  <= w_head_inc;
                r_count <= CNT_W'(r_count - 1'b1);
            end else if (i_cmd.rel_commit) begin
                r_tail  <= w_tail_inc;
                r_count <= CNT_W'(r_count + 1'b1);
            end

            if (i_cmd.scan_start) begin
                r_scan_live <= 1'b1;
                r_cmp_vld   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= r_scan_live;
                if (r_scan_idx == LAST_IDX) begin
                    r_scan_live <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_op;
            r_req <= i_req;
            r_rel <= i_rel;
        end

        if (i_cmd.scan_start) begin
            r_scan_idx  <= '0;
            r_scan_addr <= i_base;
        end else if (i_cmd.scan_step && r_scan_live) begin
            r_cmp_idx   <= r_scan_idx;
            r_cmp_addr  <= r_scan_addr;
            r_scan_idx  <= IDX_W'(r_scan_idx + 1'b1);
            r_scan_addr <= r_scan_addr + fbpa_pkg::ADDR_W'(i_stride);
        end

        if (i_cmd.res_load) begin
            o_status <= i_cmd.res_code;
            if (i_cmd.res_code == fbpa_pkg::ST_OK && !r_op) begin
                o_addr <= w_alloc_addr;
            end else begin
                o_addr <= '0;
            end
            unique case (i_cmd.res_code)
                fbpa_pkg::ST_TOO_LARGE,
                fbpa_pkg::ST_NO_FREE:     o_fatal <= i_fatal_en;
                fbpa_pkg::ST_UNKNOWN_REL: o_fatal <= 1'b1;
                default:                  o_fatal <= 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator - fixed-size block pool with a free queue
// Block i of the pool lies at pool_base + i * block_stride (modulo 2^32).
// Each slave word is an allocate (tuser 0) or a release (tuser 1) and gives
// exactly one master word: the block address, a status code and a fatal
// flag. An allocate takes the block at the head of the free queue; a
// release searches the allocated marks for the lowest block whose address
// matches and returns it to the tail of the queue. After reset and after
// every write of blocks_in_use the block runs a clearing pass through
// both RAMs with s_axis_tready low (register writes are still taken).
// An allocate passes through the decode and allocate states; a refused
// allocate or a null release is answered from the decode state; a release
// runs a search that reads one allocated mark per cycle through the single
// read port of the mark RAM into its compare stage; an unknown release is
// the longest case since it walks every block.
// One word is in flight at a time; the next slave word is accepted while
// the previous result still waits in the output register, and is then held
// in its decode cycle until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [fbpa_pkg::CFG_W-1:0]           i_cfg_wdata,
    // request stream
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    // [15:0] request_bytes, [47:16] release_address
    input  wire logic [fbpa_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] op (0 allocate, 1 release)
    input  wire logic [0:0]                           s_axis_tuser,
    // result stream
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [31:0] block_address, [34:32] status, [35] fatal, [39:36] zero
    output      logic [fbpa_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    // configuration registers
    logic [fbpa_pkg::REQ_W-1:0]    r_max_req;
    logic [fbpa_pkg::STRIDE_W-1:0] r_stride;
    logic [fbpa_pkg::ADDR_W-1:0]   r_base;
    logic [fbpa_pkg::BLK_W-1:0]    r_blocks;
    logic                          r_fatal_en;

    logic                          w_reinit;
    fbpa_pkg::t_dp_cmd             w_cmd;
    fbpa_pkg::t_dp_sts             w_sts;
    logic [fbpa_pkg::ADDR_W-1:0]   w_addr;
    logic [fbpa_pkg::STATUS_W-1:0] w_status;
    logic                          w_fatal;

    // a blocks_in_use write restarts the pool
    assign w_reinit = i_cfg_we && (i_cfg_idx == fbpa_pkg::CFG_BLOCKS);

    // register file: write only, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req  <= 16'd64;
            r_stride   <= 16'd64;
            r_base     <= 32'd4096;
            r_blocks   <= 7'd64;
            r_fatal_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbpa_pkg::CFG_MAX_REQ:  r_max_req  <= i_cfg_wdata[fbpa_pkg::REQ_W-1:0];
                fbpa_pkg::CFG_STRIDE:   r_stride   <= i_cfg_wdata[fbpa_pkg::STRIDE_W-1:0];
                fbpa_pkg::CFG_BASE:     r_base     <= i_cfg_wdata[fbpa_pkg::ADDR_W-1:0];
                fbpa_pkg::CFG_BLOCKS:   r_blocks   <= i_cfg_wdata[fbpa_pkg::BLK_W-1:0];
                fbpa_pkg::CFG_FATAL_EN: r_fatal_en <= i_cfg_wdata[0];
                default: begin
                    // unmapped index: drop the word
                end
            endcase
        end
    end

    // sequencer: handshakes and step order
    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reinit   (w_reinit),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath: queue, marks, address arithmetic, result register
    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_op       (s_axis_tuser[0]),
        .i_req      (s_axis_tdata[15:0]),
        .i_rel      (s_axis_tdata[47:16]),
        .i_max_req  (r_max_req),
        .i_stride   (r_stride),
        .i_base     (r_base),
        .i_blocks   (r_blocks),
        .i_fatal_en (r_fatal_en),
        .o_addr     (w_addr),
        .o_status   (w_status),
        .o_fatal    (w_fatal)
    );

    assign m_axis_tdata = {4'b0000, w_fatal, w_status, w_addr};

    // once a word is taken the block is not ready again in the next cycle
    a_busy_after_accept : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("request accepted on consecutive cycles");

    // a blocks_in_use write must hold off requests while the pool clears
    a_reinit_blocks : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_reinit |=> !s_axis_tready
    ) else $error("request window open after pool re-initialisation");

    // a new result never overwrites one still waiting downstream
    a_no_result_overrun : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> (!m_axis_tvalid || m_axis_tready)
    ) else $error("result register overwritten before it was taken");

    // the search reports a match or exhaustion, never both
    a_search_outcome : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_sts.hit |-> !w_sts.miss
    ) else $error("release search both matched and exhausted");

endmodule

`default_nettype wire
